/* rtl/core/keyed_unordered_table_core_assert.svh */
// Assertion macros shared by the core.
`ifndef KEYED_UNORDERED_TABLE_CORE_ASSERT_SVH
`define KEYED_UNORDERED_TABLE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KUT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define KUT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

/* rtl/core/kut_pkg.sv */
package kut_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int KEY_W            = 32;
   localparam int PAY_W            = 32;
   localparam int LIMIT_W          = 5;
   localparam int POS_W            = 4;
   localparam int COUNT_W          = 5;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_SEARCH = 2'd2,
      OP_UPDATE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_FULL    = 3'd1,
      ST_EMPTY   = 3'd2,
      ST_DUP     = 3'd3,
      ST_MISSING = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   // Lookup token that moves one cell along the row per scan cycle.
   typedef struct packed {
      logic             active;
      logic             hit;
      logic [PAY_W-1:0] payload;
   } probe_type;

   // Command broadcast from the controller to every cell.
   typedef struct packed {
      logic             advance;
      logic             insert;
      logic             shift;
      logic             update;
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } cell_cmd_type;

endpackage

/* rtl/core/kut_req_if.sv */
interface kut_req_if;
   import kut_pkg::*;

   logic                    valid;
   logic                    ready;
   op_type                  operation;
   logic signed [KEY_W-1:0] key;
   logic [PAY_W-1:0]        payload_in;

   modport source (output valid, operation, key, payload_in, input ready);
   modport sink   (input valid, operation, key, payload_in, output ready);
endinterface

/* rtl/core/kut_rsp_if.sv */
interface kut_rsp_if;
   import kut_pkg::*;

   logic               valid;
   logic               ready;
   status_type         status;
   logic [POS_W-1:0]   position;
   logic [PAY_W-1:0]   payload_out;
   logic [COUNT_W-1:0] entry_count_out;

   modport source (output valid, status, position, payload_out, entry_count_out,
                   input ready);
   modport sink   (input valid, status, position, payload_out, entry_count_out,
                   output ready);
endinterface

/* rtl/core/kut_cell.sv */
module kut_cell #(
   parameter  int CAPACITY = kut_pkg::CAPACITY_DEFAULT,
   parameter  int INDEX    = 0,
   localparam int IW       = $clog2(CAPACITY),
   localparam int CW       = $clog2(CAPACITY + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  kut_pkg::cell_cmd_type      cmd,
   input  logic [CW-1:0]              count,
   input  logic [IW-1:0]              target,
   input  kut_pkg::probe_type         probe_in,
   input  logic [IW-1:0]              probe_pos_in,
   output kut_pkg::probe_type         probe_out,
   output logic [IW-1:0]              probe_pos_out,
   input  logic [kut_pkg::KEY_W-1:0]  next_key,
   input  logic [kut_pkg::PAY_W-1:0]  next_payload,
   output logic [kut_pkg::KEY_W-1:0]  key_out,
   output logic [kut_pkg::PAY_W-1:0]  payload_out
);
   import kut_pkg::*;

   logic [KEY_W-1:0] key_ff, key_in;
   logic [PAY_W-1:0] pay_ff, pay_in;
   probe_type        probe_ff, probe_in_d;
   logic [IW-1:0]    pos_ff, pos_in;
   logic             occupied;
   logic             match;

   assign occupied = CW'(INDEX) < count;
   assign match    = cmd.advance && probe_in.active && !probe_in.hit && occupied &&
                     (key_ff == cmd.key);

   always_comb begin
      probe_in_d = probe_ff;
      pos_in     = pos_ff;
      if (cmd.advance) begin
         probe_in_d = probe_in;
         pos_in     = probe_pos_in;
         if (match) begin
            probe_in_d.hit     = 1'b1;
            probe_in_d.payload = pay_ff;
            pos_in             = IW'(INDEX);
         end
      end
   end

   always_comb begin
      priority if (cmd.insert && (CW'(INDEX) == count)) begin
         key_in = cmd.key;
         pay_in = cmd.payload;
      end else if (cmd.shift && (IW'(INDEX) >= target) && (CW'(INDEX + 1) < count)) begin
         // Close the gap left by the deleted entry.
         key_in = next_key;
         pay_in = next_payload;
      end else if (cmd.update && match) begin
         key_in = key_ff;
         pay_in = cmd.payload;
      end else begin
         key_in = key_ff;
         pay_in = pay_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in_d;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      pay_ff <= pay_in;
      pos_ff <= pos_in;
   end

   assign probe_out     = probe_ff;
   assign probe_pos_out = pos_ff;
   assign key_out       = key_ff;
   assign payload_out   = pay_ff;

endmodule

/* rtl/core/keyed_unordered_table_core.sv */
// A request transfer is followed by the scan state, in which the lookup token walks the
// row of cells one entry per cycle, and then the finish state, which commits and registers
// the response. A new request is taken only in the idle state, and the commit waits while
// an earlier response is still unaccepted; a delete closes its gap in the commit cycle.
// Reset: synchronous, active high; clears the entry count, sets the limit to 16 and
// leaves the stored keys and payloads as they are.
`include "keyed_unordered_table_core_assert.svh"

module keyed_unordered_table_core #(
   parameter int CAPACITY = kut_pkg::CAPACITY_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   kut_req_if.sink                       req_ch,
   kut_rsp_if.source                     rsp_ch,
   input  logic                          csr_we,
   input  logic [kut_pkg::LIMIT_W-1:0]   csr_wdata
);
   import kut_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int LW = CW + LIMIT_W;

   state_type          state_ff, state_in;
   logic [IW-1:0]      scan_ff, scan_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [LIMIT_W-1:0] max_entries_ff;
   op_type             op_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [PAY_W-1:0]   pay_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff, status_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [PAY_W-1:0]   pout_ff, pout_in;
   logic [COUNT_W-1:0] cnt_out_ff, cnt_out_in;

   logic               accept;
   logic               commit;
   logic               full;
   logic               ok;
   cell_cmd_type       cmd;

   probe_type          probe_w [CAPACITY+1];
   logic [IW-1:0]      ppos_w  [CAPACITY+1];
   logic [KEY_W-1:0]   key_w   [CAPACITY];
   logic [PAY_W-1:0]   pay_w   [CAPACITY];

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign commit       = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ch.ready);
   assign full         = (LW'(count_ff) >= LW'(max_entries_ff)) ||
                         (count_ff == CW'(CAPACITY));

   // The token enters the first cell only in the first scan cycle.
   assign probe_w[0].active  = (state_ff == S_SCAN) && (scan_ff == '0);
   assign probe_w[0].hit     = 1'b0;
   assign probe_w[0].payload = '0;
   assign ppos_w[0]          = '0;

   always_comb begin
      status_in = ST_OK;
      unique case (op_ff)
         OP_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else if (probe_w[CAPACITY].hit) begin
               status_in = ST_DUP;
            end
         end
         OP_DELETE, OP_SEARCH, OP_UPDATE: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else if (!probe_w[CAPACITY].hit) begin
               status_in = ST_MISSING;
            end
         end
         default: status_in = ST_OK;
      endcase
   end

   assign ok = (status_in == ST_OK);

   always_comb begin
      cmd.advance = (state_ff == S_SCAN);
      cmd.update  = (state_ff == S_SCAN) && (op_ff == OP_UPDATE);
      cmd.insert  = commit && ok && (op_ff == OP_INSERT);
      cmd.shift   = commit && ok && (op_ff == OP_DELETE);
      cmd.key     = key_ff;
      cmd.payload = pay_ff;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_W-1:0] nkey;
      logic [PAY_W-1:0] npay;

      if (i == CAPACITY - 1) begin : g_last
         assign nkey = key_w[i];
         assign npay = pay_w[i];
      end else begin : g_mid
         assign nkey = key_w[i+1];
         assign npay = pay_w[i+1];
      end

      kut_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (i)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .cmd           (cmd),
         .count         (count_ff),
         .target        (ppos_w[CAPACITY]),
         .probe_in      (probe_w[i]),
         .probe_pos_in  (ppos_w[i]),
         .probe_out     (probe_w[i+1]),
         .probe_pos_out (ppos_w[i+1]),
         .next_key      (nkey),
         .next_payload  (npay),
         .key_out       (key_w[i]),
         .payload_out   (pay_w[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      pos_in       = pos_ff;
      pout_in      = pout_ff;
      cnt_out_in   = cnt_out_ff;
      unique case (state_ff)
         S_IDLE: begin
            scan_in = '0;
            if (accept) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            scan_in = scan_ff + IW'(1);
            if (scan_ff == IW'(CAPACITY - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (commit) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               pos_in       = '0;
               pout_in      = '0;
               if (ok && (op_ff == OP_INSERT)) begin
                  count_in = count_ff + CW'(1);
                  pos_in   = POS_W'(count_ff);
               end else if (ok) begin
                  pos_in = POS_W'(ppos_w[CAPACITY]);
                  if (op_ff == OP_DELETE) begin
                     count_in = count_ff - CW'(1);
                  end else if (op_ff == OP_SEARCH) begin
                     pout_in = probe_w[CAPACITY].payload;
                  end
               end
               cnt_out_in = COUNT_W'(count_in);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         scan_ff        <= '0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         max_entries_ff <= LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            max_entries_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_ch.operation;
         key_ff <= req_ch.key;
         pay_ff <= req_ch.payload_in;
      end
      if (commit) begin
         status_ff <= status_in;
      end
      pos_ff     <= pos_in;
      pout_ff    <= pout_in;
      cnt_out_ff <= cnt_out_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = status_ff;
   assign rsp_ch.position        = pos_ff;
   assign rsp_ch.payload_out     = pout_ff;
   assign rsp_ch.entry_count_out = cnt_out_ff;

   `KUT_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY))
   `KUT_ASSERT_NEXT(a_accept_scans, clock, reset, accept, state_ff == S_SCAN)
   `KUT_ASSERT_NEXT(a_insert_grows, clock, reset, cmd.insert,
                    count_ff == $past(count_ff) + CW'(1))
   `KUT_ASSERT_SAME(a_single_edit, clock, reset, 1'b1,
                    $onehot0({cmd.insert, cmd.shift, cmd.update}))

endmodule

/* verif/keyed_unordered_table_core_test.sv */
`timescale 1ns / 1ps

module keyed_unordered_table_core_test;
   import kut_pkg::*;

   localparam int TABLE_DEPTH   = CAPACITY_DEFAULT;
   localparam int N_DIRECTED    = 27;
   localparam int RANDOM_PHASES = 7;
   localparam int PHASE_ITEMS   = 78;
   localparam int POOL_SIZE     = 12;

   typedef struct packed {
      status_type         status;
      logic [POS_W-1:0]   position;
      logic [PAY_W-1:0]   payload_out;
      logic [COUNT_W-1:0] entry_count_out;
   } table_rsp_t;

   typedef struct {
      op_type           op;
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] pay;
      int               new_limit;
      bit               typed;
      table_rsp_t       rsp;
   } directed_row_t;

   localparam table_rsp_t FROM_MODEL = '0;

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic [LIMIT_W-1:0]  csr_wdata;

   kut_req_if req_bus ();
   kut_rsp_if rsp_bus ();

   keyed_unordered_table_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the table, updated at each request transfer.
   logic [KEY_W-1:0]   table_keys     [TABLE_DEPTH];
   logic [PAY_W-1:0]   table_payloads [TABLE_DEPTH];
   int                 table_count;
   logic [LIMIT_W-1:0] table_limit;

   table_rsp_t pending_results [$];
   int         mismatches;
   int         burst_left;

   // Expected values are typed in only where they follow at a glance; the rest come
   // from the shadow table.
   directed_row_t directed_rows [N_DIRECTED] = '{
      '{OP_SEARCH, 32'h0000_0000, 32'h0000_0000, -1, 1'b1, '{ST_EMPTY,   4'd0, 32'h0, 5'd0}},
      '{OP_DELETE, 32'h7FFF_FFFF, 32'h0000_0000, -1, 1'b1, '{ST_EMPTY,   4'd0, 32'h0, 5'd0}},
      '{OP_UPDATE, 32'h8000_0000, 32'hFFFF_FFFF, -1, 1'b1, '{ST_EMPTY,   4'd0, 32'h0, 5'd0}},
      '{OP_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, -1, 1'b1, '{ST_OK,      4'd0, 32'h0, 5'd1}},
      '{OP_INSERT, 32'h7FFF_FFFF, 32'h0000_0000, -1, 1'b1, '{ST_OK,      4'd1, 32'h0, 5'd2}},
      '{OP_INSERT, 32'h0000_0000, 32'hA5A5_A5A5, -1, 1'b0, FROM_MODEL},
      '{OP_INSERT, 32'hFFFF_FFFF, 32'h5A5A_5A5A, -1, 1'b0, FROM_MODEL},
      '{OP_INSERT, 32'h8000_0000, 32'h1234_5678, -1, 1'b1, '{ST_DUP,     4'd0, 32'h0, 5'd4}},
      '{OP_SEARCH, 32'h7FFF_FFFF, 32'hFFFF_FFFF, -1, 1'b1, '{ST_OK,      4'd1, 32'h0, 5'd4}},
      '{OP_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000, -1, 1'b0, FROM_MODEL},
      '{OP_SEARCH, 32'h0000_0001, 32'h0000_0000, -1, 1'b1, '{ST_MISSING, 4'd0, 32'h0, 5'd4}},
      '{OP_UPDATE, 32'h0000_0000, 32'h1234_5678, -1, 1'b1, '{ST_OK,      4'd2, 32'h0, 5'd4}},
      '{OP_SEARCH, 32'h0000_0000, 32'h0000_0000, -1, 1'b0, FROM_MODEL},
      '{OP_DELETE, 32'h8000_0000, 32'h0000_0000, -1, 1'b1, '{ST_OK,      4'd0, 32'h0, 5'd3}},
      '{OP_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000, -1, 1'b0, FROM_MODEL},
      '{OP_DELETE, 32'hFFFF_FFFF, 32'h0000_0000, -1, 1'b0, FROM_MODEL},
      '{OP_DELETE, 32'h0000_000C, 32'h0000_0000, -1, 1'b1, '{ST_MISSING, 4'd0, 32'h0, 5'd2}},
      '{OP_UPDATE, 32'h0000_0037, 32'hDEAD_BEEF, -1, 1'b1, '{ST_MISSING, 4'd0, 32'h0, 5'd2}},
      '{OP_INSERT, 32'h0000_0063, 32'h0000_0001,  2, 1'b1, '{ST_FULL,    4'd0, 32'h0, 5'd2}},
      '{OP_INSERT, 32'h0000_0007, 32'h0000_0002,  0, 1'b1, '{ST_FULL,    4'd0, 32'h0, 5'd2}},
      '{OP_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000, -1, 1'b0, FROM_MODEL},
      '{OP_DELETE, 32'h0000_0000, 32'h0000_0000,  1, 1'b0, FROM_MODEL},
      '{OP_INSERT, 32'h0000_0008, 32'h0000_0003, -1, 1'b1, '{ST_FULL,    4'd0, 32'h0, 5'd1}},
      '{OP_INSERT, 32'h0000_0008, 32'h8000_0001, 31, 1'b0, FROM_MODEL},
      '{OP_DELETE, 32'h7FFF_FFFF, 32'h0000_0000, -1, 1'b0, FROM_MODEL},
      '{OP_DELETE, 32'h0000_0008, 32'h0000_0000, -1, 1'b0, FROM_MODEL},
      '{OP_SEARCH, 32'h0000_0008, 32'h0000_0000, -1, 1'b1, '{ST_EMPTY,   4'd0, 32'h0, 5'd0}}
   };

   always #1 clock = ~clock;

   function automatic table_rsp_t table_op_result(op_type op, logic [KEY_W-1:0] key,
                                                  logic [PAY_W-1:0] pay);
      table_rsp_t r;
      int         room;
      int         hit;
      r = '0;
      r.status = ST_OK;
      room = (table_limit < TABLE_DEPTH) ? int'(table_limit) : TABLE_DEPTH;
      // The scan runs backwards so that the first matching position wins.
      hit = table_count;
      for (int i = table_count - 1; i >= 0; i--)
         if (table_keys[i] == key) hit = i;
      if (op == OP_INSERT) begin
         if (table_count >= room) begin
            r.status = ST_FULL;
         end else if (hit < table_count) begin
            r.status = ST_DUP;
         end else begin
            r.position = POS_W'(table_count);
            table_keys[table_count] = key;
            table_payloads[table_count] = pay;
            table_count++;
         end
      end else if (table_count == 0) begin
         r.status = ST_EMPTY;
      end else if (hit == table_count) begin
         r.status = ST_MISSING;
      end else begin
         r.position = POS_W'(hit);
         case (op)
            OP_DELETE: begin
               for (int i = hit; i < table_count - 1; i++) begin
                  table_keys[i] = table_keys[i + 1];
                  table_payloads[i] = table_payloads[i + 1];
               end
               table_count--;
            end
            OP_SEARCH: r.payload_out = table_payloads[hit];
            default: table_payloads[hit] = pay;
         endcase
      end
      r.entry_count_out = COUNT_W'(table_count);
      return r;
   endfunction

   task automatic offer(op_type op, logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay,
                        bit typed, table_rsp_t typed_rsp);
      table_rsp_t predicted;
      int         gap;
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= op;
      req_bus.key        <= key;
      req_bus.payload_in <= pay;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = table_op_result(op, key, pay);
      pending_results.push_back(typed ? typed_rsp : predicted);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // The limit is only changed once the table has answered everything and a delete
   // has had time to close its gap.
   task automatic set_limit(logic [LIMIT_W-1:0] value);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      table_limit = value;
   endtask

   initial begin : request_side
      int               phase_limit  [RANDOM_PHASES];
      int               insert_share [RANDOM_PHASES];
      logic [KEY_W-1:0] key_pool     [POOL_SIZE];
      op_type           op;
      logic [KEY_W-1:0] key;
      int               roll;
      clock              = 1'b0;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.operation  = OP_INSERT;
      req_bus.key        = '0;
      req_bus.payload_in = '0;
      table_count        = 0;
      table_limit        = LIMIT_RESET;
      mismatches         = 0;
      burst_left         = 0;
      phase_limit  = '{16, 31, 5, 1, 0, 16, 12};
      insert_share = '{70, 60, 50, 55, 40, 30, 50};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < N_DIRECTED; r++) begin
         if (directed_rows[r].new_limit >= 0)
            set_limit(LIMIT_W'(directed_rows[r].new_limit));
         offer(directed_rows[r].op, directed_rows[r].key, directed_rows[r].pay,
               directed_rows[r].typed, directed_rows[r].rsp);
      end

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         set_limit(LIMIT_W'(phase_limit[ph]));
         // A small pool of keys per phase makes hits and duplicates common.
         key_pool[0] = 32'h8000_0000;
         key_pool[1] = 32'h7FFF_FFFF;
         for (int k = 2; k < POOL_SIZE; k++) key_pool[k] = $urandom();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 99) < insert_share[ph])
               op = OP_INSERT;
            else
               op = op_type'($urandom_range(1, 3));
            roll = $urandom_range(0, 9);
            if (roll < 6)
               key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else if (roll < 9 && table_count > 0)
               key = table_keys[$urandom_range(0, table_count - 1)];
            else
               key = $urandom();
            offer(op, key, $urandom(), 1'b0, FROM_MODEL);
         end
      end

      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin : result_side
      table_rsp_t got;
      table_rsp_t want;
      int         results_seen;
      int         hold_left;
      int         ready_mode;
      logic [7:0] stall_pattern;
      rsp_bus.ready = 1'b0;
      results_seen  = 0;
      hold_left     = 0;
      ready_mode    = 0;
      stall_pattern = 8'b1011_0110;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.status, rsp_bus.position, rsp_bus.payload_out,
                    rsp_bus.entry_count_out};
            results_seen++;
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result transfer: status %0d position %0d",
                           got.status, got.position);
            end else begin
               want = pending_results.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result mismatch: expected %0d/%0d/%h/%0d, got %0d/%0d/%h/%0d",
                              want.status, want.position, want.payload_out,
                              want.entry_count_out, got.status, got.position,
                              got.payload_out, got.entry_count_out);
               end
            end
            if (results_seen % 40 == 0) ready_mode = $urandom_range(0, 3);
            // Long hold-offs let the sender back up against a busy core.
            if (results_seen == 150 || results_seen == 420) hold_left = 300;
         end
         stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (ready_mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               2: rsp_bus.ready <= stall_pattern[0];
               default: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      #1_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
